/* rtl/hcb_pkg.sv */
// Shared types and constants for the Huffman code builder.
`timescale 1ns / 1ps
`default_nettype none
package hcb_pkg;

   localparam int ALPHABET_DEF     = 256;
   localparam int COUNT_BITS_DEF   = 16;
   localparam int MAX_CODE_LEN_DEF = 23;

   localparam int SYMS      = 256;
   localparam int SYM_W     = 8;
   localparam int NODE_W    = 9;
   localparam int FUNC_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int LEN_OUT_W = 5;
   localparam int VAL_OUT_W = 23;
   localparam int UNIQ_W    = 9;

   typedef enum logic [1:0] {
      FUNC_COUNT = 2'd0,
      FUNC_BUILD = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOTREE = 2'd2;

   typedef enum logic [4:0] {
      OP_NONE, OP_ACCEPT, OP_HIST_RD, OP_CNT_UPD, OP_RD_RD, OP_RD_FIN,
      OP_FILL_INIT, OP_FILL, OP_FAIL, OP_HP_INIT, OP_HP_RD, OP_HP_LD, OP_HI_DEC,
      OP_SD_RD, OP_SD_CMP, OP_POP_RD, OP_POP_LD1, OP_POP_LD2, OP_PUSH_INIT,
      OP_PUSH_RD, OP_PUSH_CMP, OP_WALK_INIT, OP_WALK_ROOT, OP_WALK_RD,
      OP_WALK_A, OP_WALK_B, OP_FIN, OP_RESP
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE, S_CNT_RD, S_CNT_UPD, S_RD_RD, S_RD_FIN, S_FILL_INIT, S_FILL,
      S_FAIL, S_HP_INIT, S_HP_RD, S_HP_LD, S_HI_DEC, S_SD_RD, S_SD_CMP,
      S_MERGE, S_POP_RD, S_POP_LD, S_PUSH_INIT, S_PUSH_RD, S_PUSH_CMP,
      S_WALK_INIT, S_WALK_ROOT, S_WALK_RD, S_WALK_A, S_WALK_B, S_FIN, S_RESP
   } state_type;

   typedef enum logic [1:0] {
      CTX_HEAPIFY,
      CTX_POP1,
      CTX_POP2
   } ctx_type;

   typedef struct packed {
      logic fill_done;
      logic heap_empty;
      logic hi_zero;
      logic sd_done;
      logic cnt_gt1;
      logic pos_zero;
      logic push_stop;
      logic walk_single;
      logic walk_last;
      logic rsp_busy;
   } dp_status_type;

endpackage
`default_nettype wire

/* rtl/hcb_ctrl.sv */
// Sequencer for counting, tree build, code walk and code reads.
`timescale 1ns / 1ps
`default_nettype none
module hcb_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic [1:0]            req_func,
   output logic                       req_ready,
   output hcb_pkg::op_type            op,
   input  wire hcb_pkg::dp_status_type status
);

   hcb_pkg::state_type state_ff, state_in;
   hcb_pkg::ctx_type   ctx_ff, ctx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hcb_pkg::S_IDLE;
         ctx_ff   <= hcb_pkg::CTX_HEAPIFY;
      end else begin
         state_ff <= state_in;
         ctx_ff   <= ctx_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctx_in    = ctx_ff;
      op        = hcb_pkg::OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         hcb_pkg::S_IDLE: begin
            req_ready = !status.rsp_busy;
            if (req_valid && !status.rsp_busy) begin
               op = hcb_pkg::OP_ACCEPT;
               case (req_func)
                  hcb_pkg::FUNC_COUNT: state_in = hcb_pkg::S_CNT_RD;
                  hcb_pkg::FUNC_BUILD: state_in = hcb_pkg::S_FILL_INIT;
                  hcb_pkg::FUNC_READ:  state_in = hcb_pkg::S_RD_RD;
                  default:             state_in = hcb_pkg::S_RESP;
               endcase
            end
         end
         hcb_pkg::S_CNT_RD: begin
            op = hcb_pkg::OP_HIST_RD;
            state_in = hcb_pkg::S_CNT_UPD;
         end
         hcb_pkg::S_CNT_UPD: begin
            op = hcb_pkg::OP_CNT_UPD;
            state_in = hcb_pkg::S_RESP;
         end
         hcb_pkg::S_RD_RD: begin
            op = hcb_pkg::OP_RD_RD;
            state_in = hcb_pkg::S_RD_FIN;
         end
         hcb_pkg::S_RD_FIN: begin
            op = hcb_pkg::OP_RD_FIN;
            state_in = hcb_pkg::S_RESP;
         end
         hcb_pkg::S_FILL_INIT: begin
            op = hcb_pkg::OP_FILL_INIT;
            state_in = hcb_pkg::S_FILL;
         end
         hcb_pkg::S_FILL: begin
            if (status.fill_done) begin
               state_in = status.heap_empty ? hcb_pkg::S_FAIL : hcb_pkg::S_HP_INIT;
            end else begin
               op = hcb_pkg::OP_FILL;
            end
         end
         hcb_pkg::S_FAIL: begin
            op = hcb_pkg::OP_FAIL;
            state_in = hcb_pkg::S_RESP;
         end
         hcb_pkg::S_HP_INIT: begin
            op = hcb_pkg::OP_HP_INIT;
            state_in = hcb_pkg::S_HP_RD;
         end
         hcb_pkg::S_HP_RD: begin
            op = hcb_pkg::OP_HP_RD;
            state_in = hcb_pkg::S_HP_LD;
         end
         hcb_pkg::S_HP_LD: begin
            op = hcb_pkg::OP_HP_LD;
            ctx_in = hcb_pkg::CTX_HEAPIFY;
            state_in = hcb_pkg::S_SD_RD;
         end
         hcb_pkg::S_HI_DEC: begin
            op = hcb_pkg::OP_HI_DEC;
            state_in = hcb_pkg::S_HP_RD;
         end
         hcb_pkg::S_SD_RD: begin
            op = hcb_pkg::OP_SD_RD;
            state_in = hcb_pkg::S_SD_CMP;
         end
         hcb_pkg::S_SD_CMP: begin
            op = hcb_pkg::OP_SD_CMP;
            if (!status.sd_done) begin
               state_in = hcb_pkg::S_SD_RD;
            end else begin
               case (ctx_ff)
                  hcb_pkg::CTX_HEAPIFY: begin
                     state_in = status.hi_zero ? hcb_pkg::S_MERGE : hcb_pkg::S_HI_DEC;
                  end
                  hcb_pkg::CTX_POP1: begin
                     ctx_in = hcb_pkg::CTX_POP2;
                     state_in = hcb_pkg::S_POP_RD;
                  end
                  default: state_in = hcb_pkg::S_PUSH_INIT;
               endcase
            end
         end
         hcb_pkg::S_MERGE: begin
            if (status.cnt_gt1) begin
               ctx_in = hcb_pkg::CTX_POP1;
               state_in = hcb_pkg::S_POP_RD;
            end else begin
               state_in = hcb_pkg::S_WALK_INIT;
            end
         end
         hcb_pkg::S_POP_RD: begin
            op = hcb_pkg::OP_POP_RD;
            state_in = hcb_pkg::S_POP_LD;
         end
         hcb_pkg::S_POP_LD: begin
            op = (ctx_ff == hcb_pkg::CTX_POP1) ? hcb_pkg::OP_POP_LD1 : hcb_pkg::OP_POP_LD2;
            state_in = hcb_pkg::S_SD_RD;
         end
         hcb_pkg::S_PUSH_INIT: begin
            op = hcb_pkg::OP_PUSH_INIT;
            state_in = hcb_pkg::S_PUSH_RD;
         end
         hcb_pkg::S_PUSH_RD: begin
            op = hcb_pkg::OP_PUSH_RD;
            state_in = status.pos_zero ? hcb_pkg::S_MERGE : hcb_pkg::S_PUSH_CMP;
         end
         hcb_pkg::S_PUSH_CMP: begin
            op = hcb_pkg::OP_PUSH_CMP;
            state_in = status.push_stop ? hcb_pkg::S_MERGE : hcb_pkg::S_PUSH_RD;
         end
         hcb_pkg::S_WALK_INIT: begin
            op = hcb_pkg::OP_WALK_INIT;
            state_in = hcb_pkg::S_WALK_ROOT;
         end
         hcb_pkg::S_WALK_ROOT: begin
            op = hcb_pkg::OP_WALK_ROOT;
            state_in = status.walk_single ? hcb_pkg::S_FIN : hcb_pkg::S_WALK_RD;
         end
         hcb_pkg::S_WALK_RD: begin
            op = hcb_pkg::OP_WALK_RD;
            state_in = hcb_pkg::S_WALK_A;
         end
         hcb_pkg::S_WALK_A: begin
            op = hcb_pkg::OP_WALK_A;
            state_in = hcb_pkg::S_WALK_B;
         end
         hcb_pkg::S_WALK_B: begin
            op = hcb_pkg::OP_WALK_B;
            state_in = status.walk_last ? hcb_pkg::S_FIN : hcb_pkg::S_WALK_RD;
         end
         hcb_pkg::S_FIN: begin
            op = hcb_pkg::OP_FIN;
            state_in = hcb_pkg::S_RESP;
         end
         hcb_pkg::S_RESP: begin
            op = hcb_pkg::OP_RESP;
            state_in = hcb_pkg::S_IDLE;
         end
         default: state_in = hcb_pkg::S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

/* rtl/hcb_datapath.sv */
// Histogram, heap, tree and code memories with their registers.
`timescale 1ns / 1ps
`default_nettype none
module hcb_datapath #(
   parameter int ALPHABET     = hcb_pkg::ALPHABET_DEF,
   parameter int COUNT_BITS   = hcb_pkg::COUNT_BITS_DEF,
   parameter int MAX_CODE_LEN = hcb_pkg::MAX_CODE_LEN_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire hcb_pkg::op_type                  op,
   input  wire logic [hcb_pkg::SYM_W-1:0]        req_symbol,
   input  wire logic                             rsp_ready,
   output hcb_pkg::dp_status_type                status,
   output logic                                  rsp_valid,
   output logic [hcb_pkg::STATUS_W-1:0]          rsp_status,
   output logic [hcb_pkg::LEN_OUT_W-1:0]         rsp_code_length,
   output logic [hcb_pkg::VAL_OUT_W-1:0]         rsp_code_value,
   output logic [hcb_pkg::UNIQ_W-1:0]            rsp_unique_count,
   output logic                                  rsp_overflowed
);

   localparam int CB = COUNT_BITS;
   localparam int ML = MAX_CODE_LEN;
   localparam int LW = $clog2(MAX_CODE_LEN + 1);
   localparam int CW = LW + ML;
   localparam int NW = hcb_pkg::NODE_W;
   localparam int EW = CB + NW;
   localparam int LOW = hcb_pkg::LEN_OUT_W;
   localparam int VOW = hcb_pkg::VAL_OUT_W;
   localparam int NODES = 2 * hcb_pkg::SYMS;
   localparam logic [NW-1:0] ALPH_V = NW'(ALPHABET);
   localparam logic [NW-1:0] SYMS_V = NW'(hcb_pkg::SYMS);

   // memories
   logic [CB-1:0]     hist_ff [hcb_pkg::SYMS];
   logic              hv_ff   [hcb_pkg::SYMS];
   logic [EW-1:0]     heap_ff [hcb_pkg::SYMS];
   logic [2*NW-1:0]   kids_ff [NODES];
   logic [CW-1:0]     code_ff [NODES];

   // registered read data
   logic [CB-1:0]   histq_ff;
   logic            hvq_ff;
   logic [EW-1:0]   rda_ff, rdb_ff;
   logic [2*NW-1:0] kq_ff;
   logic [CW-1:0]   cq_ff;

   // state and working registers
   logic [7:0]              sym_ff, sym_in;
   logic [CB-1:0]           total_ff, total_in;
   logic                    drop_ff, drop_in;
   logic [hcb_pkg::UNIQ_W-1:0] uniq_ff, uniq_in;
   logic                    tree_ff, tree_in;
   logic [hcb_pkg::STATUS_W-1:0] stat_ff, stat_in;
   logic [LW-1:0]           len_ff, len_in;
   logic [ML-1:0]           val_ff, val_in;
   logic [NW-1:0]           cnt_ff, cnt_in;
   logic [NW-1:0]           next_ff, next_in;
   logic [NW-1:0]           scan_ff, scan_in;
   logic                    pend_ff, pend_in;
   logic [7:0]              psym_ff, psym_in;
   logic [7:0]              hi_ff, hi_in;
   logic [7:0]              pos_ff, pos_in;
   logic [NW-1:0]           wi_ff, wi_in;
   logic [EW-1:0]           x_ff, x_in, a_ff, a_in, b_ff, b_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [hcb_pkg::STATUS_W-1:0] rsp_stat_ff, rsp_stat_in;
   logic [LOW-1:0]          rsp_len_ff, rsp_len_in;
   logic [VOW-1:0]          rsp_val_ff, rsp_val_in;
   logic [hcb_pkg::UNIQ_W-1:0] rsp_uniq_ff, rsp_uniq_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;

   // memory controls
   logic            hist_re, hist_we;
   logic [7:0]      hist_ra, hist_wa;
   logic [CB-1:0]   hist_wd;
   logic            a_re, b_re, heap_we;
   logic [7:0]      a_ra, b_ra, heap_wa;
   logic [EW-1:0]   heap_wd;
   logic            kids_re, kids_we;
   logic [NW-1:0]   kids_ra, kids_wa;
   logic [2*NW-1:0] kids_wd;
   logic            code_re, code_we;
   logic [NW-1:0]   code_ra, code_wa;
   logic [CW-1:0]   code_wd;

   // helpers
   logic [CB-1:0]   hdata, xw, raw, rbw, smw;
   logic            sym_ok, lt_l, lt_r, push_lt, grow;
   logic [9:0]      lidx, ridx, cnt10;
   logic [7:0]      parent, pos_m1;
   logic [NW-1:0]   cnt_m1;
   logic [CB:0]     wsum;
   logic [LW-1:0]   code_len, len_p1;
   logic [ML-1:0]   code_val;
   logic [CW-1:0]   child0, child1;
   logic [LW+LOW-1:0] len_ext;
   logic [ML+VOW-1:0] val_ext;

   assign hdata    = hvq_ff ? histq_ff : '0;
   assign sym_ok   = {1'b0, sym_ff} < ALPH_V;
   assign xw       = x_ff[EW-1:NW];
   assign raw      = rda_ff[EW-1:NW];
   assign rbw      = rdb_ff[EW-1:NW];
   assign cnt10    = {1'b0, cnt_ff};
   assign lidx     = {1'b0, pos_ff, 1'b1};
   assign ridx     = {1'b0, pos_ff, 1'b0} + 10'd2;
   assign lt_l     = (lidx < cnt10) && (raw < xw);
   assign smw      = lt_l ? raw : xw;
   assign lt_r     = (ridx < cnt10) && (rbw < smw);
   assign pos_m1   = pos_ff - 8'd1;
   assign parent   = {1'b0, pos_m1[7:1]};
   assign push_lt  = xw < raw;
   assign cnt_m1   = cnt_ff - NW'(1);
   assign wsum     = {1'b0, a_ff[EW-1:NW]} + {1'b0, b_ff[EW-1:NW]};
   assign code_len = cq_ff[CW-1:ML];
   assign code_val = cq_ff[ML-1:0];
   assign grow     = code_len < LW'(ML);
   assign len_p1   = code_len + LW'(1);
   assign child0   = grow ? {len_p1, code_val[ML-2:0], 1'b0} : cq_ff;
   assign child1   = grow ? {len_p1, code_val[ML-2:0], 1'b1} : cq_ff;
   assign len_ext  = {{LOW{1'b0}}, len_ff};
   assign val_ext  = {{VOW{1'b0}}, val_ff};

   always_comb begin
      status.fill_done   = !(scan_ff < ALPH_V) && !pend_ff;
      status.heap_empty  = (cnt_ff == '0);
      status.hi_zero     = (hi_ff == 8'd0);
      status.sd_done     = !lt_l && !lt_r;
      status.cnt_gt1     = (cnt_ff > NW'(1));
      status.pos_zero    = (pos_ff == 8'd0);
      status.push_stop   = !push_lt;
      status.walk_single = (next_ff == SYMS_V);
      status.walk_last   = (wi_ff == SYMS_V);
      status.rsp_busy    = rsp_valid_ff;
   end

   always_comb begin
      sym_in = sym_ff;  total_in = total_ff; drop_in = drop_ff; uniq_in = uniq_ff;
      tree_in = tree_ff; stat_in = stat_ff; len_in = len_ff; val_in = val_ff;
      cnt_in = cnt_ff;  next_in = next_ff;   scan_in = scan_ff; pend_in = pend_ff;
      psym_in = psym_ff; hi_in = hi_ff; pos_in = pos_ff; wi_in = wi_ff;
      x_in = x_ff; a_in = a_ff; b_in = b_ff;
      rsp_stat_in = rsp_stat_ff; rsp_len_in = rsp_len_ff; rsp_val_in = rsp_val_ff;
      rsp_uniq_in = rsp_uniq_ff; rsp_ovf_in = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      hist_re = 1'b0; hist_ra = sym_ff; hist_we = 1'b0; hist_wa = sym_ff; hist_wd = '0;
      a_re = 1'b0; a_ra = 8'd0; b_re = 1'b0; b_ra = 8'd0;
      heap_we = 1'b0; heap_wa = pos_ff; heap_wd = x_ff;
      kids_re = 1'b0; kids_ra = wi_ff; kids_we = 1'b0; kids_wa = next_ff; kids_wd = '0;
      code_re = 1'b0; code_ra = wi_ff; code_we = 1'b0; code_wa = wi_ff; code_wd = '0;
      case (op)
         hcb_pkg::OP_ACCEPT: begin
            sym_in  = req_symbol;
            stat_in = hcb_pkg::ST_OK;
            len_in  = '0;
            val_in  = '0;
         end
         hcb_pkg::OP_HIST_RD: hist_re = 1'b1;
         hcb_pkg::OP_CNT_UPD: begin
            if (sym_ok) begin
               if (&total_ff) begin
                  drop_in = 1'b1;
               end else begin
                  hist_we  = 1'b1;
                  hist_wd  = hdata + CB'(1);
                  total_in = total_ff + CB'(1);
                  tree_in  = 1'b0;
                  if (hdata == '0) begin
                     uniq_in = uniq_ff + 9'd1;
                  end
               end
            end
         end
         hcb_pkg::OP_RD_RD: begin
            hist_re = 1'b1;
            code_re = 1'b1;
            code_ra = {1'b0, sym_ff};
         end
         hcb_pkg::OP_RD_FIN: begin
            if (!tree_ff) begin
               stat_in = hcb_pkg::ST_NOTREE;
            end else if (!sym_ok || hdata == '0) begin
               stat_in = hcb_pkg::ST_ABSENT;
            end else begin
               len_in = code_len;
               val_in = code_val;
            end
         end
         hcb_pkg::OP_FILL_INIT: begin
            cnt_in  = '0;
            scan_in = '0;
            pend_in = 1'b0;
            next_in = SYMS_V;
         end
         hcb_pkg::OP_FILL: begin
            if (scan_ff < ALPH_V) begin
               hist_re = 1'b1;
               hist_ra = scan_ff[7:0];
               scan_in = scan_ff + NW'(1);
               pend_in = 1'b1;
               psym_in = scan_ff[7:0];
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && hdata != '0) begin
               heap_we = 1'b1;
               heap_wa = cnt_ff[7:0];
               heap_wd = {hdata, 1'b0, psym_ff};
               cnt_in  = cnt_ff + NW'(1);
            end
         end
         hcb_pkg::OP_FAIL: begin
            tree_in = 1'b0;
            stat_in = hcb_pkg::ST_NOTREE;
         end
         hcb_pkg::OP_HP_INIT: hi_in = cnt_ff[8:1];
         hcb_pkg::OP_HP_RD: begin
            a_re = 1'b1;
            a_ra = hi_ff;
         end
         hcb_pkg::OP_HP_LD: begin
            x_in   = rda_ff;
            pos_in = hi_ff;
         end
         hcb_pkg::OP_HI_DEC: hi_in = hi_ff - 8'd1;
         hcb_pkg::OP_SD_RD: begin
            a_re = 1'b1;
            a_ra = lidx[7:0];
            b_re = 1'b1;
            b_ra = ridx[7:0];
         end
         hcb_pkg::OP_SD_CMP: begin
            heap_we = 1'b1;
            if (lt_r) begin
               heap_wd = rdb_ff;
               pos_in  = ridx[7:0];
            end else if (lt_l) begin
               heap_wd = rda_ff;
               pos_in  = lidx[7:0];
            end
         end
         hcb_pkg::OP_POP_RD: begin
            a_re = 1'b1;
            b_re = 1'b1;
            b_ra = cnt_m1[7:0];
         end
         hcb_pkg::OP_POP_LD1, hcb_pkg::OP_POP_LD2: begin
            if (op == hcb_pkg::OP_POP_LD1) begin
               a_in = rda_ff;
            end else begin
               b_in = rda_ff;
            end
            x_in   = rdb_ff;
            pos_in = 8'd0;
            cnt_in = cnt_m1;
         end
         hcb_pkg::OP_PUSH_INIT: begin
            kids_we = 1'b1;
            kids_wd = {a_ff[NW-1:0], b_ff[NW-1:0]};
            x_in    = {wsum[CB-1:0], next_ff};
            pos_in  = cnt_ff[7:0];
            cnt_in  = cnt_ff + NW'(1);
         end
         hcb_pkg::OP_PUSH_RD: begin
            if (pos_ff == 8'd0) begin
               heap_we = 1'b1;
               next_in = next_ff + NW'(1);
            end else begin
               a_re = 1'b1;
               a_ra = parent;
            end
         end
         hcb_pkg::OP_PUSH_CMP: begin
            heap_we = 1'b1;
            if (push_lt) begin
               heap_wd = rda_ff;
               pos_in  = parent;
            end else begin
               next_in = next_ff + NW'(1);
            end
         end
         hcb_pkg::OP_WALK_INIT: a_re = 1'b1;
         hcb_pkg::OP_WALK_ROOT: begin
            code_we = 1'b1;
            code_wa = rda_ff[NW-1:0];
            wi_in   = next_ff - NW'(1);
            cnt_in  = '0;
         end
         hcb_pkg::OP_WALK_RD: begin
            kids_re = 1'b1;
            code_re = 1'b1;
         end
         hcb_pkg::OP_WALK_A: begin
            code_we = 1'b1;
            code_wa = kq_ff[2*NW-1:NW];
            code_wd = child0;
         end
         hcb_pkg::OP_WALK_B: begin
            code_we = 1'b1;
            code_wa = kq_ff[NW-1:0];
            code_wd = child1;
            wi_in   = wi_ff - NW'(1);
         end
         hcb_pkg::OP_FIN: begin
            tree_in = 1'b1;
            stat_in = hcb_pkg::ST_OK;
         end
         hcb_pkg::OP_RESP: begin
            rsp_valid_in = 1'b1;
            rsp_stat_in  = stat_ff;
            rsp_len_in   = len_ext[LOW-1:0];
            rsp_val_in   = val_ext[VOW-1:0];
            rsp_uniq_in  = uniq_ff;
            rsp_ovf_in   = drop_ff;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         drop_ff      <= 1'b0;
         uniq_ff      <= '0;
         tree_ff      <= 1'b0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         drop_ff      <= drop_in;
         uniq_ff      <= uniq_in;
         tree_ff      <= tree_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sym_ff <= sym_in;   stat_ff <= stat_in; len_ff <= len_in; val_ff <= val_in;
      next_ff <= next_in; scan_ff <= scan_in; psym_ff <= psym_in;
      hi_ff <= hi_in;     pos_ff <= pos_in;   wi_ff <= wi_in;
      x_ff <= x_in;       a_ff <= a_in;       b_ff <= b_in;
      rsp_stat_ff <= rsp_stat_in; rsp_len_ff <= rsp_len_in; rsp_val_ff <= rsp_val_in;
      rsp_uniq_ff <= rsp_uniq_in; rsp_ovf_ff <= rsp_ovf_in;
   end

   // histogram valid bits: an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < hcb_pkg::SYMS; i++) begin
            hv_ff[i] <= 1'b0;
         end
      end else if (hist_we) begin
         hv_ff[hist_wa] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_ff[hist_wa] <= hist_wd;
      end
      if (hist_re) begin
         histq_ff <= hist_ff[hist_ra];
         hvq_ff   <= hv_ff[hist_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (heap_we) begin
         heap_ff[heap_wa] <= heap_wd;
      end
      if (a_re) begin
         rda_ff <= heap_ff[a_ra];
      end
      if (b_re) begin
         rdb_ff <= heap_ff[b_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (kids_we) begin
         kids_ff[kids_wa] <= kids_wd;
      end
      if (kids_re) begin
         kq_ff <= kids_ff[kids_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (code_we) begin
         code_ff[code_wa] <= code_wd;
      end
      if (code_re) begin
         cq_ff <= code_ff[code_ra];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_stat_ff;
   assign rsp_code_length  = rsp_len_ff;
   assign rsp_code_value   = rsp_val_ff;
   assign rsp_unique_count = rsp_uniq_ff;
   assign rsp_overflowed   = rsp_ovf_ff;

   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      (op == hcb_pkg::OP_RESP) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken beat");
   a_drop_sticky: assert property (@(posedge clock) disable iff (reset)
      drop_ff |=> drop_ff)
      else $error("drop flag cleared");
   a_heap_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= SYMS_V)
      else $error("heap count beyond alphabet");
   a_uniq_bound: assert property (@(posedge clock) disable iff (reset)
      32'(uniq_ff) <= 32'(total_ff))
      else $error("more distinct symbols than bytes");
   a_tree_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(tree_ff) |-> ($past(op) == hcb_pkg::OP_FIN))
      else $error("tree marked ready outside build end");

endmodule
`default_nettype wire

/* rtl/huffman_code_builder_core.sv */
// Top level of the Huffman code builder: sequencer plus datapath.
//
//   channel  direction  ports                                       beat
//   req      in         req_valid/req_ready, req_func, req_symbol   one command
//   rsp      out        rsp_valid/rsp_ready, rsp_status, rsp_code_*,  one result per command
//                       rsp_unique_count, rsp_overflowed
//
// A count command reads and then updates the histogram entry before its result beat;
// a read command reads the histogram and code entries first; an unused function code
// goes straight to the result. A build scans the leaves, then moves one heap level
// per step in each sift or push, and walks the internal nodes to code their children.
// Reset is synchronous; the histogram is empty at once through per-entry valid
// bits, so no clearing pass follows reset. A new command is taken only while the
// sequencer is idle and the result register is empty; the result register holds
// its beat through any rsp_ready stall.
`timescale 1ns / 1ps
`default_nettype none
module huffman_code_builder_core #(
   parameter int ALPHABET     = hcb_pkg::ALPHABET_DEF,
   parameter int COUNT_BITS   = hcb_pkg::COUNT_BITS_DEF,
   parameter int MAX_CODE_LEN = hcb_pkg::MAX_CODE_LEN_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [hcb_pkg::FUNC_W-1:0]       req_func,
   input  wire logic [hcb_pkg::SYM_W-1:0]        req_symbol,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [hcb_pkg::STATUS_W-1:0]          rsp_status,
   output logic [hcb_pkg::LEN_OUT_W-1:0]         rsp_code_length,
   output logic [hcb_pkg::VAL_OUT_W-1:0]         rsp_code_value,
   output logic [hcb_pkg::UNIQ_W-1:0]            rsp_unique_count,
   output logic                                  rsp_overflowed
);

   // sequencer command and datapath status
   hcb_pkg::op_type        op;
   hcb_pkg::dp_status_type dp_status;

   hcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .op        (op),
      .status    (dp_status)
   );

   hcb_datapath #(
      .ALPHABET     (ALPHABET),
      .COUNT_BITS   (COUNT_BITS),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .op               (op),
      .req_symbol       (req_symbol),
      .rsp_ready        (rsp_ready),
      .status           (dp_status),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_code_length  (rsp_code_length),
      .rsp_code_value   (rsp_code_value),
      .rsp_unique_count (rsp_unique_count),
      .rsp_overflowed   (rsp_overflowed)
   );

endmodule
`default_nettype wire
